### hw/rtl/lav_pkg.sv
`default_nettype none
package lav_pkg;

  // coordinate and matrix entry width
  localparam int COORD_W = 32;
  localparam int ENTRY_W = 32;
  // components are scaled below 2^NORM_BITS before squaring
  localparam int NORM_BITS = 30;

  typedef enum logic [1:0] {
    ROW_X = 2'd0,
    ROW_Y = 2'd1,
    ROW_Z = 2'd2,
    ROW_W = 2'd3
  } row_t;

endpackage
`default_nettype wire

### hw/rtl/lookat_view_matrix.sv
`default_nettype none
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  eye, target, up vectors (Q16.16)
// m_axis   out  m_axis_tvalid/m_axis_tready  one view matrix row, tuser = row,
//                                            tlast on the final row
//
// One input word yields four output words, so the output port, one row a cycle
// while m_axis_tready is high, sets the input rate.
// The path from input to first row runs mostly through the bit-per-stage
// square root and divider of the three normalizers.
// rst is synchronous and clears every valid bit and the row sequencer.
// One enable moves the whole pipeline; it drops only while the row buffer is
// full and not about to be freed, so a stall holds every stage in place.
module lookat_view_matrix #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z,
  // upward_x, upward_y, upward_z, 32 bits each from bit 0 up
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_0, entry_1, entry_2, entry_3, 32 bits each from bit 0 up
  output logic [127:0] m_axis_tdata,
  // row_index
  output logic [1:0]   m_axis_tuser,
  // last_row
  output logic         m_axis_tlast
);
  import lav_pkg::*;

  localparam int FB  = FRACTION_BITS;
  localparam int UW  = FB + 2;              // unit component width
  localparam int XW  = COORD_W + UW + 1;    // raw x width
  localparam int YW  = 2 * UW + 1;          // raw y width
  localparam int EW3 = 3 * COORD_W;
  localparam int UW3 = 3 * UW;

  logic adv;

  // capture the input word
  logic                      v0;
  logic signed [COORD_W-1:0] eye0 [3];
  logic signed [COORD_W-1:0] tgt0 [3];
  logic signed [COORD_W-1:0] up0  [3];

  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        eye0[i] <= s_axis_tdata[COORD_W*i +: COORD_W];
        tgt0[i] <= s_axis_tdata[COORD_W*(3+i) +: COORD_W];
        up0[i]  <= s_axis_tdata[COORD_W*(6+i) +: COORD_W];
      end
    end
  end

  // forward vector
  logic                    v1;
  logic signed [COORD_W:0] fwd1 [3];
  logic [2*EW3-1:0]        side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) fwd1[i] <= (COORD_W+1)'(eye0[i]) - (COORD_W+1)'(tgt0[i]);
      side1 <= {up0[2], up0[1], up0[0], eye0[2], eye0[1], eye0[0]};
    end
  end

  // normalize z
  logic                      zv;
  logic signed [UW-1:0]      z_u [3];
  logic [2*EW3-1:0]          z_side;
  logic signed [COORD_W-1:0] z_up [3];
  logic [EW3-1:0]            z_eye;

  lav_norm #(.VW(COORD_W + 1), .FB(FB), .SW(2 * EW3)) u_norm_z (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(v1), .in_vec(fwd1), .in_side(side1),
    .out_valid(zv), .out_unit(z_u), .out_side(z_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) z_up[i] = z_side[EW3 + COORD_W*i +: COORD_W];
    z_eye = z_side[EW3-1:0];
  end

  // x = up cross z
  logic                 xrv;
  logic signed [XW-1:0] xr [3];
  logic [EW3+UW3-1:0]   xr_side;

  lav_cross #(.AW(COORD_W), .BW(UW), .SW(EW3 + UW3)) u_cross_x (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(zv), .in_a(z_up), .in_b(z_u),
    .in_side({z_u[2], z_u[1], z_u[0], z_eye}),
    .out_valid(xrv), .out_c(xr), .out_side(xr_side)
  );

  // normalize x
  logic                 xv;
  logic signed [UW-1:0] x_u [3];
  logic [EW3+UW3-1:0]   x_side;
  logic signed [UW-1:0] x_z [3];

  lav_norm #(.VW(XW), .FB(FB), .SW(EW3 + UW3)) u_norm_x (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(xrv), .in_vec(xr), .in_side(xr_side),
    .out_valid(xv), .out_unit(x_u), .out_side(x_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) x_z[i] = x_side[EW3 + UW*i +: UW];
  end

  // y = z cross x
  logic                   yrv;
  logic signed [YW-1:0]   yr [3];
  logic [EW3+2*UW3-1:0]   yr_side;

  lav_cross #(.AW(UW), .BW(UW), .SW(EW3 + 2 * UW3)) u_cross_y (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(xv), .in_a(x_z), .in_b(x_u),
    .in_side({x_u[2], x_u[1], x_u[0], x_side}),
    .out_valid(yrv), .out_c(yr), .out_side(yr_side)
  );

  // normalize y
  logic                      yv;
  logic signed [UW-1:0]      y_u [3];
  logic [EW3+2*UW3-1:0]      y_side;
  logic signed [UW-1:0]      rows [3][3];
  logic signed [COORD_W-1:0] y_eye [3];

  lav_norm #(.VW(YW), .FB(FB), .SW(EW3 + 2 * UW3)) u_norm_y (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(yrv), .in_vec(yr), .in_side(yr_side),
    .out_valid(yv), .out_unit(y_u), .out_side(y_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y_eye[i]   = y_side[COORD_W*i +: COORD_W];
      rows[2][i] = y_side[EW3 + UW*i +: UW];
      rows[0][i] = y_side[EW3 + UW3 + UW*i +: UW];
      rows[1][i] = y_u[i];
    end
  end

  // translation column
  logic                      tv;
  logic signed [UW-1:0]      t_row [3][3];
  logic signed [ENTRY_W-1:0] t_tr  [3];

  lav_xlat #(.FB(FB)) u_xlat (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(yv), .in_row(rows), .in_eye(y_eye),
    .out_valid(tv), .out_row(t_row), .out_trans(t_tr)
  );

  // row buffer: hold one matrix, send its four rows in order
  logic                      busy;
  row_t                      row;
  logic signed [UW-1:0]      mat   [3][3];
  logic signed [ENTRY_W-1:0] trans [3];

  assign adv = !tv || !busy || (m_axis_tready && row == ROW_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= ROW_X;
    end else if (adv && tv) begin
      busy <= 1'b1;
      row  <= ROW_X;
    end else if (busy && m_axis_tready) begin
      if (row == ROW_W) busy <= 1'b0;
      else row <= row_t'(row + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tv) begin
      mat   <= t_row;
      trans <= t_tr;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tuser  = row;
  assign m_axis_tlast  = (row == ROW_W);

  always_comb begin
    case (row)
      ROW_X: m_axis_tdata = {trans[0], ENTRY_W'(mat[0][2]), ENTRY_W'(mat[0][1]),
                             ENTRY_W'(mat[0][0])};
      ROW_Y: m_axis_tdata = {trans[1], ENTRY_W'(mat[1][2]), ENTRY_W'(mat[1][1]),
                             ENTRY_W'(mat[1][0])};
      ROW_Z: m_axis_tdata = {trans[2], ENTRY_W'(mat[2][2]), ENTRY_W'(mat[2][1]),
                             ENTRY_W'(mat[2][0])};
      ROW_W: m_axis_tdata = {ENTRY_W'(1) << FB, {(3*ENTRY_W){1'b0}}};
      default: m_axis_tdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/lav_norm.sv
`default_nettype none
module lav_norm #(
  parameter int VW = 33,
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] in_vec [3],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [FB+1:0] out_unit [3],
  output logic [SW-1:0]        out_side
);
  import lav_pkg::*;

  localparam int SHW  = $clog2(VW + 1);
  localparam int SQ_N = 32;
  localparam int DV_N = FB + 1;
  localparam int LW   = NORM_BITS + 1;
  localparam int RW   = NORM_BITS + 2;

  // magnitude and sign
  logic          v1;
  logic [VW-1:0] mag1 [3];
  logic [2:0]    neg1;
  logic [SW-1:0] side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_vec[i][VW-1];
        mag1[i] <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
      end
      side1 <= in_side;
    end
  end

  // scale shift from the widest magnitude
  logic [VW-1:0]  orv;
  logic [SHW-1:0] blen;
  logic [SHW-1:0] sh_next;

  assign orv = mag1[0] | mag1[1] | mag1[2];

  always_comb begin
    blen = '0;
    for (int j = 0; j < VW; j++) begin
      if (orv[j]) blen = SHW'(j + 1);
    end
    sh_next = (blen > SHW'(NORM_BITS)) ? blen - SHW'(NORM_BITS) : '0;
  end

  logic           v2;
  logic [VW-1:0]  mag2 [3];
  logic [2:0]     neg2;
  logic [SHW-1:0] sh2;
  logic [SW-1:0]  side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag2  <= mag1;
      neg2  <= neg1;
      sh2   <= sh_next;
      side2 <= side1;
    end
  end

  // scaled magnitudes
  logic                 v3;
  logic [NORM_BITS-1:0] a3 [3];
  logic [2:0]           neg3;
  logic [SW-1:0]        side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) a3[i] <= NORM_BITS'(mag2[i] >> sh2);
      neg3  <= neg2;
      side3 <= side2;
    end
  end

  // squares
  logic                   v4;
  logic [2*NORM_BITS-1:0] sq4 [3];
  logic [NORM_BITS-1:0]   a4 [3];
  logic [2:0]             neg4;
  logic [SW-1:0]          side4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= (2*NORM_BITS)'(a3[i]) * (2*NORM_BITS)'(a3[i]);
      end
      a4    <= a3;
      neg4  <= neg3;
      side4 <= side3;
    end
  end

  // square root, one result bit per stage; entry 0 holds the sum
  logic                 sq_v    [SQ_N+1];
  logic [63:0]          sq_n    [SQ_N+1];
  logic [63:0]          sq_r    [SQ_N+1];
  logic [NORM_BITS-1:0] sq_a    [SQ_N+1][3];
  logic [2:0]           sq_neg  [SQ_N+1];
  logic [SW-1:0]        sq_side [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n[0]    <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
      sq_r[0]    <= '0;
      sq_a[0]    <= a4;
      sq_neg[0]  <= neg4;
      sq_side[0] <= side4;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;

    assign trial = sq_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_n[k] >= trial) begin
          sq_n[k+1] <= sq_n[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
        end else begin
          sq_n[k+1] <= sq_n[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
        sq_a[k+1]    <= sq_a[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // division of magnitude by length, one quotient bit per stage
  logic          dv_v    [DV_N+1];
  logic [RW-1:0] dv_rem  [DV_N+1][3];
  logic [FB:0]   dv_q    [DV_N+1][3];
  logic [LW-1:0] dv_len  [DV_N+1];
  logic [2:0]    dv_neg  [DV_N+1];
  logic [SW-1:0] dv_side [DV_N+1];

  always_comb begin
    dv_v[0] = sq_v[SQ_N];
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = RW'(sq_a[SQ_N][i]);
      dv_q[0][i]   = '0;
    end
    dv_len[0]  = LW'(sq_r[SQ_N]);
    dv_neg[0]  = sq_neg[SQ_N];
    dv_side[0] = sq_side[SQ_N];
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [RW-1:0] rin [3];
    logic [2:0]    ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rin[i] = (j == 0) ? dv_rem[j][i] : {dv_rem[j][i][RW-2:0], 1'b0};
        ge[i]  = rin[i] >= RW'(dv_len[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (adv) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? rin[i] - RW'(dv_len[j]) : rin[i];
          dv_q[j+1][i]   <= {dv_q[j][i][FB-1:0], ge[i]};
        end
        dv_len[j+1]  <= dv_len[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // restore sign; a zero vector stays zero
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_v[DV_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_len[DV_N] == '0) out_unit[i] <= '0;
        else if (dv_neg[DV_N][i]) out_unit[i] <= -$signed({1'b0, dv_q[DV_N][i]});
        else out_unit[i] <= $signed({1'b0, dv_q[DV_N][i]});
      end
      out_side <= dv_side[DV_N];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lav_cross.sv
`default_nettype none
module lav_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [AW-1:0]    in_a [3],
  input  logic signed [BW-1:0]    in_b [3],
  input  logic [SW-1:0]           in_side,
  output logic                    out_valid,
  output logic signed [AW+BW:0]   out_c [3],
  output logic [SW-1:0]           out_side
);
  localparam int PW = AW + BW;

  logic                 v1;
  logic signed [PW-1:0] p1 [6];
  logic [SW-1:0]        side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0] <= in_a[1] * in_b[2];
      p1[1] <= in_a[2] * in_b[1];
      p1[2] <= in_a[2] * in_b[0];
      p1[3] <= in_a[0] * in_b[2];
      p1[4] <= in_a[0] * in_b[1];
      p1[5] <= in_a[1] * in_b[0];
      side1 <= in_side;
      out_c[0] <= (PW+1)'(p1[0]) - (PW+1)'(p1[1]);
      out_c[1] <= (PW+1)'(p1[2]) - (PW+1)'(p1[3]);
      out_c[2] <= (PW+1)'(p1[4]) - (PW+1)'(p1[5]);
      out_side <= side1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lav_xlat.sv
`default_nettype none
module lav_xlat #(
  parameter int FB = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [FB+1:0]    in_row [3][3],
  input  logic signed [lav_pkg::COORD_W-1:0] in_eye [3],
  output logic                    out_valid,
  output logic signed [FB+1:0]    out_row [3][3],
  output logic signed [lav_pkg::ENTRY_W-1:0] out_trans [3]
);
  import lav_pkg::*;

  localparam int PW = FB + 2 + COORD_W;
  localparam int DW = PW + 2;
  localparam logic [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);
  localparam logic [DW-1:0] NEG_LIM = DW'(64'h8000_0000);

  logic                 v1, v2;
  logic signed [PW-1:0] p1 [3][3];
  logic signed [FB+1:0] row1 [3][3];
  logic signed [FB+1:0] row2 [3][3];
  logic signed [DW-1:0] dot2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // products, then dot products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) p1[r][c] <= in_row[r][c] * in_eye[c];
        dot2[r] <= DW'(p1[r][0]) + DW'(p1[r][1]) + DW'(p1[r][2]);
      end
      row1 <= in_row;
      row2 <= row1;
    end
  end

  // negate, drop fraction toward zero, saturate
  logic [DW-1:0]        mg [3];
  logic [DW-1:0]        m  [3];
  logic [ENTRY_W-1:0]   t  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mg[r] = dot2[r][DW-1] ? DW'(-dot2[r]) : DW'(dot2[r]);
      m[r]  = mg[r] >> FB;
      if (!dot2[r][DW-1] && dot2[r] != '0) begin
        t[r] = ENTRY_W'(-((m[r] > NEG_LIM) ? NEG_LIM : m[r]));
      end else begin
        t[r] = ENTRY_W'((m[r] > POS_LIM) ? POS_LIM : m[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) out_trans[r] <= $signed(t[r]);
      out_row <= row2;
    end
  end

endmodule
`default_nettype wire

### tb/sv/lookat_view_matrix_test.sv
`default_nettype none
module lookat_view_matrix_test;
  import lav_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 3 * FRAC + 140;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    row_t                row;
    logic signed [31:0]  ent [4];
    logic                last;
  } row_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  row_word_t pending_rows[$];
  int mismatches = 0;
  longint cycle = 0;
  bit sending_done = 1'b0;
  bit hold_long = 1'b0;

  lookat_view_matrix #(.FRACTION_BITS(FRAC)) DUT (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // magnitude of a signed 64-bit value, as unsigned
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale down until below 2^30, then divide by the floor length
  function automatic void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned a[3], m, sum, len, q;
    int sh;
    m = 0; sum = 0; sh = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(v[i]);
      if (a[i] > m) m = a[i];
    end
    while ((m >> sh) >= (64'd1 << NORM_BITS)) sh++;
    for (int i = 0; i < 3; i++) begin
      a[i] >>= sh;
      sum += a[i] * a[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (len == 0) ? 0 : (a[i] << FRAC) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // -(row . eye), truncated toward zero and saturated
  function automatic logic signed [31:0] neg_dot(longint r[3], longint e[3]);
    longint d;
    longint unsigned m;
    d = r[0] * e[0] + r[1] * e[1] + r[2] * e[2];
    m = abs64(d) >> FRAC;
    if (d > 0) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-longint'(m));
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return 32'(m);
  endfunction

  task automatic predict_view(input logic [287:0] w);
    longint eye[3], up[3], fwd[3], zu[3], xr[3], xu[3], yr[3], yu[3];
    row_word_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(w[32*i +: 32]));
      fwd[i] = eye[i] - longint'($signed(w[32*(i+3) +: 32]));
      up[i] = longint'($signed(w[32*(i+6) +: 32]));
    end
    unit_vec(fwd, zu);
    cross_prod(up, zu, xr);
    unit_vec(xr, xu);
    cross_prod(zu, xu, yr);
    unit_vec(yr, yu);
    r.last = 1'b0;
    r.row = ROW_X;
    for (int i = 0; i < 3; i++) r.ent[i] = 32'(xu[i]);
    r.ent[3] = neg_dot(xu, eye);
    pending_rows.push_back(r);
    r.row = ROW_Y;
    for (int i = 0; i < 3; i++) r.ent[i] = 32'(yu[i]);
    r.ent[3] = neg_dot(yu, eye);
    pending_rows.push_back(r);
    r.row = ROW_Z;
    for (int i = 0; i < 3; i++) r.ent[i] = 32'(zu[i]);
    r.ent[3] = neg_dot(zu, eye);
    pending_rows.push_back(r);
    r.row = ROW_W;
    r.ent[0] = 0; r.ent[1] = 0; r.ent[2] = 0;
    r.ent[3] = 32'sd1 <<< FRAC;
    r.last = 1'b1;
    pending_rows.push_back(r);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC;
      3: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
      4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // short gaps mostly, a long one now and then
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // directed words: eye, target, up as 3 coordinates each
  localparam int N_DIRECTED = 12;
  logic [31:0] directed_words [N_DIRECTED][9];
  initial begin
    logic [31:0] one, mn, mx;
    one = 32'h0001_0000; mn = 32'h8000_0000; mx = 32'h7FFF_FFFF;
    directed_words = '{
      '{0, 0, one, 0, 0, 0, 0, one, 0},          // plain view down -z
      '{0, 0, 0, 0, 0, 0, 0, one, 0},            // eye equals target
      '{0, one, 0, 0, 0, 0, 0, one, 0},          // up parallel to forward
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},              // all zero
      '{mx, mx, mx, mn, mn, mn, mx, mn, mx},     // extremes, shifts needed
      '{mn, mn, mn, mx, mx, mx, mn, mx, mn},
      '{mx, mn, mx, 0, 0, 0, one, 0, 0},         // saturating translation
      '{mn, mx, mn, 0, 0, 0, 0, 0, one},
      '{32'hFFFF_FFFF, 1, 0, 0, 0, 0, 1, 1, 1},  // tiny lengths
      '{one, 2*one, 3*one, 0, 0, 0, 0, 0, mx},
      '{0, 0, 0, mn, mn, mn, mn, 0, 0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
        32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h3333_3333, 32'hCCCC_CCCC, 32'h7777_7777}
    };
  end

  task automatic send_word(input logic [287:0] w);
    int g;
    s_axis_tdata <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_view(w);
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    logic [287:0] w;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // row 3 of the plain view is known outright; the predictor agrees
    for (int n = 0; n < N_DIRECTED; n++) begin
      for (int k = 0; k < 9; k++) w[32*k +: 32] = directed_words[n][k];
      send_word(w);
    end
    for (int n = 0; n < 260; n++) begin
      for (int k = 0; k < 9; k++) w[32*k +: 32] = rand_coord();
      if (n == 40) hold_long = 1'b1;
      send_word(w);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: random stalls, one long hold while the sender keeps offering
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 2000; hold++) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // checker: compare each accepted row with the oldest prediction
  always @(posedge clk) begin
    row_word_t exp_row;
    logic [127:0] exp_data;
    cycle <= cycle + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row: tuser=%0d", m_axis_tuser);
      end else begin
        exp_row = pending_rows.pop_front();
        for (int i = 0; i < 4; i++) exp_data[32*i +: 32] = exp_row.ent[i];
        if (m_axis_tuser !== exp_row.row || m_axis_tlast !== exp_row.last ||
            m_axis_tdata !== exp_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: exp row=%0d last=%0b data=%h, got row=%0d last=%0b data=%h",
                     exp_row.row, exp_row.last, exp_data,
                     m_axis_tuser, m_axis_tlast, m_axis_tdata);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (sending_done && pending_rows.size() == 0);
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (cycle >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
